// ===== hdl/tunsc_pkg.sv =====
// Shared types and widths for the scaled triangle unit-normal pipeline.
`default_nettype none
package tunsc_pkg;

    // Field and datapath widths
    localparam int COORD_W = 32;
    localparam int OUT_W   = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = 2 * COORD_W + 3;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int TOP_W   = $clog2(MAG_W + 1);
    localparam int C_W     = 31;
    localparam int SQR_W   = 2 * C_W;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int FRAC_W  = 30;
    localparam int DEN_W   = ROOT_W + 4;
    localparam int NUM_W   = 64;
    localparam int QUO_W   = 28;

    // Input transaction: three corners, signed Q16.16
    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } t_tri_in;

    // Output transaction: normal / 10 in signed Q2.30
    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } t_nrm_out;

    // Sign and degenerate flags that ride along the datapath
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_sgn;

    // Scaled magnitudes plus flags, carried through the square root
    typedef struct packed {
        logic [2:0][C_W-1:0] c;
        t_sgn                sgn;
    } t_tag;

endpackage
`default_nettype wire

// ===== hdl/tunsc_cross.sv =====
// Edge vectors, exact cross product and component magnitudes (four stages).
`default_nettype none
module tunsc_cross (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_ce,
    input  wire logic                                  i_valid,
    input  wire tunsc_pkg::t_tri_in                    i_tri,
    output logic                                       o_valid,
    output logic [2:0][tunsc_pkg::MAG_W-1:0]           o_mag,
    output logic [2:0]                                 o_neg
);
    import tunsc_pkg::*;

    logic [3:0]                       r_vld;
    logic signed [DIFF_W-1:0]         r_u [3];
    logic signed [DIFF_W-1:0]         r_v [3];
    logic signed [PROD_W-1:0]         r_p [6];
    logic signed [CROSS_W-1:0]        r_n [3];
    logic [2:0][MAG_W-1:0]            r_mag;
    logic [2:0]                       r_neg;
    logic signed [DIFF_W-1:0]         n_u [3];
    logic signed [DIFF_W-1:0]         n_v [3];

    // Edge differences, exact at one extra bit
    always_comb begin
        n_u[0] = DIFF_W'(i_tri.second_x) - DIFF_W'(i_tri.first_x);
        n_u[1] = DIFF_W'(i_tri.second_y) - DIFF_W'(i_tri.first_y);
        n_u[2] = DIFF_W'(i_tri.second_z) - DIFF_W'(i_tri.first_z);
        n_v[0] = DIFF_W'(i_tri.third_x) - DIFF_W'(i_tri.first_x);
        n_v[1] = DIFF_W'(i_tri.third_y) - DIFF_W'(i_tri.first_y);
        n_v[2] = DIFF_W'(i_tri.third_z) - DIFF_W'(i_tri.first_z);
    end

    // Valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= n_u[i];
                r_v[i] <= n_v[i];
            end
            // six partial products
            r_p[0] <= r_u[1] * r_v[2];
            r_p[1] <= r_u[2] * r_v[1];
            r_p[2] <= r_u[2] * r_v[0];
            r_p[3] <= r_u[0] * r_v[2];
            r_p[4] <= r_u[0] * r_v[1];
            r_p[5] <= r_u[1] * r_v[0];
            // cross components
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= CROSS_W'(r_p[2*i]) - CROSS_W'(r_p[2*i+1]);
            end
            // sign and magnitude
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_n[i][CROSS_W-1];
                r_mag[i] <= r_n[i][CROSS_W-1] ? MAG_W'(-r_n[i]) : MAG_W'(r_n[i]);
            end
        end
    end

    assign o_valid = r_vld[3];
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule
`default_nettype wire

// ===== hdl/tunsc_scale.sv =====
// Block scaling to 31 bits and sum of squares (four stages).
`default_nettype none
module tunsc_scale (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_ce,
    input  wire logic                                  i_valid,
    input  wire logic [2:0][tunsc_pkg::MAG_W-1:0]      i_mag,
    input  wire logic [2:0]                            i_neg,
    output logic                                       o_valid,
    output logic [tunsc_pkg::SUM_W-1:0]                o_sum,
    output tunsc_pkg::t_tag                            o_tag
);
    import tunsc_pkg::*;

    logic [3:0]              r_vld;
    logic [2:0][MAG_W-1:0]   r_mag;
    logic [2:0]              r_neg;
    logic [TOP_W-1:0]        r_top;
    t_tag                    r_tag1;
    t_tag                    r_tag2;
    t_tag                    r_tag3;
    logic [SQR_W-1:0]        r_sq [3];
    logic [SUM_W-1:0]        r_sum;
    logic [MAG_W-1:0]        n_or;
    logic [TOP_W-1:0]        n_top;
    t_tag                    n_tag;

    // Bit length of the largest magnitude
    always_comb begin
        n_or  = i_mag[0] | i_mag[1] | i_mag[2];
        n_top = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (n_or[i]) n_top = TOP_W'(i + 1);
        end
    end

    // Common shift that brings the top bit to position 30
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_top > TOP_W'(C_W)) begin
                n_tag.c[i] = C_W'(r_mag[i] >> (r_top - TOP_W'(C_W)));
            end else begin
                n_tag.c[i] = C_W'(r_mag[i] << (TOP_W'(C_W) - r_top));
            end
        end
        n_tag.sgn.neg   = r_neg;
        n_tag.sgn.degen = (r_top == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_mag  <= i_mag;
            r_neg  <= i_neg;
            r_top  <= n_top;
            r_tag1 <= n_tag;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQR_W'(r_tag1.c[i]) * SQR_W'(r_tag1.c[i]);
            end
            r_tag2 <= r_tag1;
            r_sum  <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_tag3 <= r_tag2;
        end
    end

    assign o_valid = r_vld[3];
    assign o_sum   = r_sum;
    assign o_tag   = r_tag3;

endmodule
`default_nettype wire

// ===== hdl/tunsc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tunsc_sqrt (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_ce,
    input  wire logic                                  i_valid,
    input  wire logic [tunsc_pkg::SUM_W-1:0]           i_x,
    input  wire tunsc_pkg::t_tag                       i_tag,
    output logic                                       o_valid,
    output logic [tunsc_pkg::ROOT_W-1:0]               o_root,
    output tunsc_pkg::t_tag                            o_tag
);
    import tunsc_pkg::*;

    localparam int T_W = SUM_W + 2;

    logic [ROOT_W-1:0]   r_vld;
    logic [SUM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    t_tag                r_tag  [ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[ROOT_W-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;
        logic [SUM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        t_tag              w_tag_in;
        logic [T_W-1:0]    w_trial;
        logic [SUM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_x;
            assign w_root_in = '0;
            assign w_tag_in  = i_tag;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_tag_in  = r_tag[k-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        always_comb begin
            w_trial = (T_W'(w_root_in) << (B + 1)) + (T_W'(1) << (2 * B));
            n_rem   = w_rem_in;
            n_root  = w_root_in;
            if (T_W'(w_rem_in) >= w_trial) begin
                n_rem  = w_rem_in - SUM_W'(w_trial);
                n_root = w_root_in | (ROOT_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_tag[k]  <= w_tag_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_tag   = r_tag[ROOT_W-1];

endmodule
`default_nettype wire

// ===== hdl/tunsc_div.sv =====
// Rounded division of the three scaled components by ten times the length.
`default_nettype none
module tunsc_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_ce,
    input  wire logic                                  i_valid,
    input  wire logic [tunsc_pkg::ROOT_W-1:0]          i_len,
    input  wire tunsc_pkg::t_tag                       i_tag,
    output logic                                       o_valid,
    output logic [2:0][tunsc_pkg::QUO_W-1:0]           o_quo,
    output tunsc_pkg::t_sgn                            o_sgn
);
    import tunsc_pkg::*;

    localparam int STEPS = QUO_W + 1;

    logic [STEPS-1:0]          r_vld;
    logic [2:0][NUM_W-1:0]     r_rem [STEPS];
    logic [2:0][QUO_W-1:0]     r_quo [STEPS];
    logic [DEN_W-1:0]          r_den [STEPS];
    t_sgn                      r_sgn [STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[STEPS-2:0], i_valid};
        end
    end

    // Setup: numerator c * 2^30 + 5L, divisor 10L
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (NUM_W'(i_tag.c[i]) << FRAC_W)
                             + (NUM_W'(i_len) << 2) + NUM_W'(i_len);
            end
            r_quo[0] <= '0;
            r_den[0] <= (DEN_W'(i_len) << 3) + (DEN_W'(i_len) << 1);
            r_sgn[0] <= i_tag.sgn;
        end
    end

    // Restoring long division, one quotient bit per stage
    for (genvar k = 1; k < STEPS; k++) begin : g_step
        localparam int B = QUO_W - k;
        logic [NUM_W-1:0]      w_ds;
        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0] n_quo;

        always_comb begin
            w_ds = NUM_W'(r_den[k-1]) << B;
            for (int i = 0; i < 3; i++) begin
                n_rem[i] = r_rem[k-1][i];
                n_quo[i] = r_quo[k-1][i];
                if (r_rem[k-1][i] >= w_ds) begin
                    n_rem[i] = r_rem[k-1][i] - w_ds;
                    n_quo[i] = r_quo[k-1][i] | (QUO_W'(1) << B);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_den[k] <= r_den[k-1];
                r_sgn[k] <= r_sgn[k-1];
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_quo   = r_quo[STEPS-1];
    assign o_sgn   = r_sgn[STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/triangle_unit_normal_scaled.sv =====
// Top level: triangle face normal, normalized and scaled by one tenth.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------
//  input    | i_valid  | o_stall  | i_tri (three Q16.16 corners)
//  output   | o_valid  | i_stall  | o_nrm (Q2.30 normal, degenerate)
//
// One transaction per cycle while the output is not stalled; the stages are 4 cross-product,
// 4 scaling, 32 square-root, 29 divider and 1 output stage.
// The 32-step square root and the 28-bit quotient set the depth.
// Reset clears only the valid bits; data registers are not reset.
// A stall on the output freezes the whole pipeline while the output holds
// a transaction, and o_stall then stops the input in the same cycle.
`default_nettype none
module triangle_unit_normal_scaled (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire tunsc_pkg::t_tri_in   i_tri,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output tunsc_pkg::t_nrm_out       o_nrm
);
    import tunsc_pkg::*;

    logic                  w_ce;
    logic                  w_x_vld;
    logic [2:0][MAG_W-1:0] w_mag;
    logic [2:0]            w_neg;
    logic                  w_s_vld;
    logic [SUM_W-1:0]      w_sum;
    t_tag                  w_s_tag;
    logic                  w_r_vld;
    logic [ROOT_W-1:0]     w_root;
    t_tag                  w_r_tag;
    logic                  w_d_vld;
    logic [2:0][QUO_W-1:0] w_quo;
    t_sgn                  w_sgn;
    logic                  r_out_vld;
    t_nrm_out              r_out;
    logic [OUT_W-1:0]      n_comp [3];

    // Advance everything unless a held result is stalled
    assign w_ce    = !(r_out_vld && i_stall);
    assign o_stall = !w_ce;

    tunsc_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_valid),
        .i_tri   (i_tri),
        .o_valid (w_x_vld),
        .o_mag   (w_mag),
        .o_neg   (w_neg)
    );

    tunsc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_x_vld),
        .i_mag   (w_mag),
        .i_neg   (w_neg),
        .o_valid (w_s_vld),
        .o_sum   (w_sum),
        .o_tag   (w_s_tag)
    );

    tunsc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_s_vld),
        .i_x     (w_sum),
        .i_tag   (w_s_tag),
        .o_valid (w_r_vld),
        .o_root  (w_root),
        .o_tag   (w_r_tag)
    );

    tunsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_r_vld),
        .i_len   (w_root),
        .i_tag   (w_r_tag),
        .o_valid (w_d_vld),
        .o_quo   (w_quo),
        .o_sgn   (w_sgn)
    );

    // Apply signs; degenerate triangles give zeros
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_sgn.degen) begin
                n_comp[i] = '0;
            end else if (w_sgn.neg[i]) begin
                n_comp[i] = -OUT_W'(w_quo[i]);
            end else begin
                n_comp[i] = OUT_W'(w_quo[i]);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out.normal_x   <= n_comp[0];
            r_out.normal_y   <= n_comp[1];
            r_out.normal_z   <= n_comp[2];
            r_out.degenerate <= w_sgn.degen;
        end
    end

    assign o_valid = r_out_vld;
    assign o_nrm   = r_out;

    // A degenerate result carries an all-zero normal
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_nrm.degenerate) |->
            (o_nrm.normal_x == '0 && o_nrm.normal_y == '0 && o_nrm.normal_z == '0))
        else $error("degenerate result with nonzero normal");

    // The x component magnitude stays within about 2^30 / 10
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_nrm.normal_x) <= $signed(32'sd107374183) &&
                     $signed(o_nrm.normal_x) >= -$signed(32'sd107374183)))
        else $error("normal_x out of range");

    // Input stalls exactly when the held output is stalled
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output stall");

    // A frozen pipeline does not drop the held result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_nrm)))
        else $error("held result lost under stall");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the scaled triangle unit-normal pipeline.
`default_nettype none
module tb;
    import tunsc_pkg::*;

    localparam int LATENCY   = 70;
    localparam int N_RANDOM  = 2000;
    localparam longint LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_tri_in  tri_in;
    logic     out_valid;
    logic     out_stall;
    t_nrm_out nrm_out;

    t_nrm_out expected_normals[$];
    int       n_errors;
    longint   cycle;
    logic     hold_off;
    logic     stim_done;

    triangle_unit_normal_scaled dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_tri   (tri_in),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_nrm   (nrm_out)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Integer square root, floor
    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bit_q;
        rem   = x;
        root  = '0;
        bit_q = 64'd1 << 62;
        while (bit_q > rem) bit_q = bit_q >> 2;
        while (bit_q != 0) begin
            if (rem >= root + bit_q) begin
                rem  = rem - (root + bit_q);
                root = (root >> 1) + bit_q;
            end else begin
                root = root >> 1;
            end
            bit_q = bit_q >> 2;
        end
        return root[31:0];
    endfunction

    // Normal of the triangle, unit length scaled by one tenth
    function automatic t_nrm_out face_normal(input t_tri_in t);
        logic signed [DIFF_W-1:0]  u [3];
        logic signed [DIFF_W-1:0]  v [3];
        logic signed [CROSS_W-1:0] n [3];
        logic [CROSS_W-1:0]        m [3];
        logic [63:0]               c [3];
        logic [63:0]               q [3];
        logic [63:0]               sum;
        logic [63:0]               len;
        int                        top;
        int                        sh;
        t_nrm_out                  r;
        u[0] = DIFF_W'(t.second_x) - DIFF_W'(t.first_x);
        u[1] = DIFF_W'(t.second_y) - DIFF_W'(t.first_y);
        u[2] = DIFF_W'(t.second_z) - DIFF_W'(t.first_z);
        v[0] = DIFF_W'(t.third_x) - DIFF_W'(t.first_x);
        v[1] = DIFF_W'(t.third_y) - DIFF_W'(t.first_y);
        v[2] = DIFF_W'(t.third_z) - DIFF_W'(t.first_z);
        n[0] = CROSS_W'(u[1]) * CROSS_W'(v[2]) - CROSS_W'(u[2]) * CROSS_W'(v[1]);
        n[1] = CROSS_W'(u[2]) * CROSS_W'(v[0]) - CROSS_W'(u[0]) * CROSS_W'(v[2]);
        n[2] = CROSS_W'(u[0]) * CROSS_W'(v[1]) - CROSS_W'(u[1]) * CROSS_W'(v[0]);
        top = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = n[i] < 0 ? -n[i] : n[i];
            for (int b = 0; b < CROSS_W; b++) if (m[i][b] && b + 1 > top) top = b + 1;
        end
        r = '0;
        if (top == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        // Block scaling so the largest magnitude lands in [2^30, 2^31)
        sh = top - 31;
        for (int i = 0; i < 3; i++)
            c[i] = sh >= 0 ? 64'(m[i] >> sh) : 64'(m[i]) << (-sh);
        sum = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        len = 64'(floor_sqrt(sum));
        for (int i = 0; i < 3; i++) begin
            q[i] = ((c[i] << 30) + len * 5) / (len * 10);
            if (n[i] < 0) q[i] = -q[i];
        end
        r.normal_x = q[0][31:0];
        r.normal_y = q[1][31:0];
        r.normal_z = q[2][31:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_tri_in rand_triangle();
        t_tri_in t;
        t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(0, 9))
            // coincident corners
            0: begin
                t.second_x = t.first_x; t.second_y = t.first_y; t.second_z = t.first_z;
            end
            // collinear: third = second + (second - first) in a small range
            1: begin
                t.first_x  = 32'($signed($urandom_range(0, 4000)) - 2000);
                t.first_y  = 32'($signed($urandom_range(0, 4000)) - 2000);
                t.first_z  = 32'($signed($urandom_range(0, 4000)) - 2000);
                t.second_x = 32'($signed($urandom_range(0, 4000)) - 2000);
                t.second_y = 32'($signed($urandom_range(0, 4000)) - 2000);
                t.second_z = 32'($signed($urandom_range(0, 4000)) - 2000);
                t.third_x  = 2 * t.second_x - t.first_x;
                t.third_y  = 2 * t.second_y - t.first_y;
                t.third_z  = 2 * t.second_z - t.first_z;
            end
            default: ;
        endcase
        return t;
    endfunction

    // Directed stimulus; check_fixed marks rows whose result is typed in
    typedef struct {
        t_tri_in  tri_q;
        bit       check_fixed;
        t_nrm_out fixed;
    } t_row;

    t_row directed[$];

    task automatic add_row(input t_tri_in t, input bit fixed_ok, input t_nrm_out f);
        t_row r;
        r.tri_q       = t;
        r.check_fixed = fixed_ok;
        r.fixed       = f;
        directed.push_back(r);
    endtask

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [31:0] MINC = 32'h8000_0000;
    // one tenth in Q2.30, rounded
    localparam logic [31:0] TENTH = 32'd107374182;

    // Drive one transaction; valid stays high into the next one when there is no gap
    task automatic send(input t_tri_in t, input t_nrm_out exp_r);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        tri_in   <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_normals.push_back(exp_r);
        @(negedge clk);
    endtask

    // Sender
    initial begin
        t_tri_in t;
        in_valid  = 1'b0;
        tri_in    = '0;
        rst_n     = 1'b0;
        hold_off  = 1'b0;
        stim_done = 1'b0;
        n_errors  = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        add_row('0, 1'b1, '{0, 0, 0, 1'b1});
        add_row('{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1'b1, '{0, 0, TENTH, 1'b0});
        add_row('{0, 0, 0, 0, ONE, 0, ONE, 0, 0}, 1'b1, '{0, 0, -TENTH, 1'b0});
        add_row('{0, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1, '{TENTH, 0, 0, 1'b0});
        add_row('{0, 0, 0, 0, 0, ONE, ONE, 0, 0}, 1'b1, '{0, TENTH, 0, 1'b0});
        add_row('{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1'b1,
                '{0, 0, 0, 1'b1});
        add_row('{1, 2, 3, 2, 4, 6, 3, 6, 9}, 1'b1, '{0, 0, 0, 1'b1});
        add_row('{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC}, 1'b1,
                '{0, 0, TENTH, 1'b0});
        add_row('{MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC}, 1'b1,
                '{0, 0, TENTH, 1'b0});
        add_row('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b1, '{0, 0, TENTH, 1'b0});
        add_row('{MINC, 0, MAXC, MAXC, MINC, 0, 0, MAXC, MINC}, 1'b0, '0);
        add_row('{MAXC, MINC, MAXC, MINC, MAXC, MINC, 1, -1, 0}, 1'b0, '0);
        add_row('{0, 0, 0, ONE, ONE, 0, 0, ONE, ONE}, 1'b0, '0);
        add_row('{-1, -1, -1, 0, 1, 2, 5, -3, 7}, 1'b0, '0);
        add_row('{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
                  32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0001,
                  32'hDEAD_BEEF}, 1'b0, '0);

        foreach (directed[k]) begin
            if (directed[k].check_fixed)
                send(directed[k].tri_q, directed[k].fixed);
            else
                send(directed[k].tri_q, face_normal(directed[k].tri_q));
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            // long receiver hold-off while items keep coming
            if (k == 300) hold_off = 1'b1;
            if (k == 500) hold_off = 1'b0;
            // sender pause until the pipeline drains
            if (k == 1000) begin
                in_valid <= 1'b0;
                wait (expected_normals.size() == 0);
                @(negedge clk);
            end
            t = rand_triangle();
            send(t, face_normal(t));
        end
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall
    initial begin
        int wait_n;
        bit held;
        out_stall = 1'b0;
        held      = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            // one long hold-off
            if (hold_off && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                @(negedge clk);
            end
            wait_n = $urandom_range(0, 5);
            if (cycle % 4000 < 1000) wait_n = 0;
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n - 1) @(negedge clk);
                @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Result checking
    always @(posedge clk) begin
        t_nrm_out e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_normals.size() == 0) begin
                $error("result with no expectation: %h", nrm_out);
                n_errors++;
            end else begin
                e = expected_normals.pop_front();
                if (nrm_out.normal_x !== e.normal_x) begin
                    $error("normal_x expected %h got %h", e.normal_x, nrm_out.normal_x);
                    n_errors++;
                end
                if (nrm_out.normal_y !== e.normal_y) begin
                    $error("normal_y expected %h got %h", e.normal_y, nrm_out.normal_y);
                    n_errors++;
                end
                if (nrm_out.normal_z !== e.normal_z) begin
                    $error("normal_z expected %h got %h", e.normal_z, nrm_out.normal_z);
                    n_errors++;
                end
                if (nrm_out.degenerate !== e.degenerate) begin
                    $error("degenerate expected %b got %b", e.degenerate, nrm_out.degenerate);
                    n_errors++;
                end
            end
        end
    end

    // Cycle limit and end of run
    initial cycle = 0;
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_normals.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (n_errors == 0 && expected_normals.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== triangle_unit_normal_scaled.f =====
hdl/tunsc_pkg.sv
hdl/tunsc_cross.sv
hdl/tunsc_scale.sv
hdl/tunsc_sqrt.sv
hdl/tunsc_div.sv
hdl/triangle_unit_normal_scaled.sv
sim/tb.sv
